>>> hdl/lpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lpr_pkg;
    localparam int TimeW  = 32;
    localparam int CfgW   = 16;
    localparam int NumCfg = 5;
    localparam int IdxW   = 3;
    // Modulus and divisor width: count*cycle+pause fits 8+16+1 bits.
    localparam int ModW   = 25;
    // Quotient of the level division never exceeds 510.
    localparam int QW     = 9;
    // Side data through the modulo pipes: rgb, mode, period, total, in-sequence time.
    localparam int MSideW = 24 + 3 + 16 + 24 + ModW;
    // Side data through the level divider: rgb, mode, blink lit, degenerate period.
    localparam int DSideW = 24 + 3 + 1 + 1;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_SOLID = 3'd1,
        MODE_SLOW  = 3'd2,
        MODE_FAST  = 3'd3,
        MODE_BLINK = 3'd4
    } t_mode;

    localparam logic [IdxW-1:0] REG_SLOW  = 3'd0;
    localparam logic [IdxW-1:0] REG_FAST  = 3'd1;
    localparam logic [IdxW-1:0] REG_CYCLE = 3'd2;
    localparam logic [IdxW-1:0] REG_ON    = 3'd3;
    localparam logic [IdxW-1:0] REG_PAUSE = 3'd4;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [2:0] pattern_mode;
        logic [7:0] pulse_count;
        logic [TimeW-1:0] time_ms;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] level;
    } t_out;

    typedef struct packed {
        logic [CfgW-1:0] slow;
        logic [CfgW-1:0] fast;
        logic [CfgW-1:0] cycle;
        logic [CfgW-1:0] on_ms;
        logic [CfgW-1:0] pause;
    } t_cfg;

    // Restoring-division step: shift in one dividend bit, try subtract.
    typedef struct packed {
        logic [ModW:0]   rem;
        logic [TimeW-1:0] num;
    } t_div;
endpackage
`default_nettype wire

>>> hdl/lpr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface lpr_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/lpr_mod_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined modulo: one quotient bit per stage, value and side data carried.
module lpr_mod_pipe
    import lpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [TimeW-1:0]  i_num,
    input  wire logic [ModW-1:0]   i_den,
    input  wire logic [MSideW-1:0] i_side,
    output logic                   o_valid,
    output logic [ModW-1:0]        o_rem,
    output logic [MSideW-1:0]      o_side
);
    logic [TimeW:0]        r_v;
    logic [ModW:0]         r_rem  [TimeW+1];
    logic [TimeW-1:0]      r_num  [TimeW+1];
    logic [ModW-1:0]       r_den  [TimeW+1];
    logic [MSideW-1:0]     r_side [TimeW+1];

    always_comb begin
        r_rem[0]  = '0;
        r_num[0]  = i_num;
        r_den[0]  = i_den;
        r_side[0] = i_side;
        r_v[0]    = i_valid;
    end

    for (genvar k = 0; k < TimeW; k++) begin : g_st
        logic [ModW:0] n_sh;
        logic [ModW:0] n_rem;
        always_comb begin
            n_sh  = {r_rem[k][ModW-1:0], r_num[k][TimeW-1]};
            n_rem = (n_sh >= {1'b0, r_den[k]}) ? n_sh - {1'b0, r_den[k]} : n_sh;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_num[k+1]  <= {r_num[k][TimeW-2:0], 1'b0};
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[TimeW];
    assign o_rem   = r_rem[TimeW][ModW-1:0];
    assign o_side  = r_side[TimeW];
endmodule
`default_nettype wire

>>> hdl/lpr_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined quotient of a 24-bit numerator by a 15-bit divisor, QW bits kept.
module lpr_div_pipe
    import lpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [23:0]       i_num,
    input  wire logic [14:0]       i_den,
    input  wire logic [DSideW-1:0] i_side,
    output logic                   o_valid,
    output logic [QW-1:0]          o_quo,
    output logic [DSideW-1:0]      o_side
);
    // Quotient fits QW bits, so the top 15 numerator bits seed the remainder.
    logic [QW:0]        r_v;
    logic [15:0]        r_rem  [QW+1];
    logic [QW-1:0]      r_num  [QW+1];
    logic [QW-1:0]      r_q    [QW+1];
    logic [14:0]        r_den  [QW+1];
    logic [DSideW-1:0]  r_side [QW+1];

    always_comb begin
        r_rem[0]  = {1'b0, i_num[23:QW]};
        r_num[0]  = i_num[QW-1:0];
        r_q[0]    = '0;
        r_den[0]  = i_den;
        r_side[0] = i_side;
        r_v[0]    = i_valid;
    end

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic [16:0] n_sh;
        logic        n_ge;
        always_comb begin
            n_sh = {r_rem[k], r_num[k][QW-1]};
            n_ge = n_sh >= {2'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= n_ge ? 16'(n_sh - {2'b0, r_den[k]}) : n_sh[15:0];
                r_num[k+1]  <= {r_num[k][QW-2:0], 1'b0};
                r_q[k+1]    <= {r_q[k][QW-2:0], n_ge};
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_q[QW];
    assign o_side  = r_side[QW];
endmodule
`default_nettype wire

>>> hdl/led_pattern_renderer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload                                        Handshake
// s_in      in   red/green/blue_in, pattern_mode, pulse_count,  valid/ready
//                time_ms
// m_out     out  red/green/blue_out, level                       valid/ready
// config    in   i_cfg_we, i_cfg_idx, i_cfg_data                 write enable
//
// One transaction per cycle sustained while m_out is ready; the bit-per-stage
// modulo pipelines (sequence, then cycle) and the bit-per-stage level divider
// make up most of the pipe. The whole pipe advances together and holds on
// a stall; ready runs back combinationally from the sink through the output
// register. Reset clears all valid bits and loads the register defaults.
module led_pattern_renderer
    import lpr_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [IdxW-1:0] i_cfg_idx,
    input  wire logic [CfgW-1:0] i_cfg_data,
    lpr_if.sink                  s_in,
    lpr_if.source                m_out
);
    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{slow: 16'd2000, fast: 16'd600, cycle: 16'd500,
                       on_ms: 16'd250, pause: 16'd1000};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SLOW:  r_cfg.slow  <= i_cfg_data;
                REG_FAST:  r_cfg.fast  <= i_cfg_data;
                REG_CYCLE: r_cfg.cycle <= i_cfg_data;
                REG_ON:    r_cfg.on_ms <= i_cfg_data;
                REG_PAUSE: r_cfg.pause <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipe unless the output register is full and stalled.
    logic r_ov;
    t_out r_od;
    logic w_en;
    assign w_en        = !r_ov || m_out.ready;
    assign s_in.ready  = w_en;
    assign m_out.valid = r_ov;
    assign m_out.data  = r_od;

    t_in w_in;
    assign w_in = s_in.data;

    // Stage 1: pick the modulus. Breathe uses the period, blink the sequence.
    logic            r1_v;
    logic [23:0]     r1_rgb;
    logic [2:0]      r1_mode;
    logic [ModW-1:0] r1_mod;
    logic [23:0]     r1_total;
    logic [15:0]     r1_per;
    logic [TimeW-1:0] r1_t;
    logic [7:0]      n_cnt;
    logic [15:0]     n_per;
    always_comb begin
        n_cnt = (w_in.pulse_count == 8'd0) ? 8'd1 : w_in.pulse_count;
        n_per = (w_in.pattern_mode == MODE_FAST) ? r_cfg.fast : r_cfg.slow;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= s_in.valid;
        end
        if (w_en) begin
            r1_rgb   <= {w_in.red_in, w_in.green_in, w_in.blue_in};
            r1_mode  <= w_in.pattern_mode;
            r1_total <= 24'(n_cnt * r_cfg.cycle);
            r1_per   <= n_per;
            r1_t     <= w_in.time_ms;
        end
    end

    logic [ModW-1:0] w_mod1;
    always_comb begin
        if (r1_mode == MODE_BLINK) begin
            w_mod1 = ModW'(r1_total) + ModW'(r_cfg.pause);
        end else begin
            w_mod1 = ModW'(r1_per);
        end
    end
    // Guard against zero modulus: result is unused in that case.
    assign r1_mod = (w_mod1 == '0) ? ModW'(1) : w_mod1;

    logic              m1_v;
    logic [ModW-1:0]   m1_rem;
    logic [MSideW-1:0] m1_side;
    lpr_mod_pipe u_mod_seq (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r1_v),
        .i_num(r1_t), .i_den(r1_mod),
        .i_side({r1_rgb, r1_mode, r1_per, r1_total, ModW'(0)}),
        .o_valid(m1_v), .o_rem(m1_rem), .o_side(m1_side)
    );
    logic [23:0] m1_rgb;
    logic [2:0]  m1_mode;
    logic [15:0] m1_per;
    logic [23:0] m1_total;
    assign {m1_rgb, m1_mode, m1_per, m1_total} = m1_side[MSideW-1:ModW];

    // Second modulo: in_seq mod cycle. Carry in_seq alongside.
    logic              m2_v;
    logic [ModW-1:0]   m2_rem;
    logic [MSideW-1:0] m2_side;
    lpr_mod_pipe u_mod_cyc (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(m1_v),
        .i_num(TimeW'(m1_rem)),
        .i_den((r_cfg.cycle == '0) ? ModW'(1) : ModW'(r_cfg.cycle)),
        .i_side({m1_rgb, m1_mode, m1_per, m1_total, m1_rem}),
        .o_valid(m2_v), .o_rem(m2_rem), .o_side(m2_side)
    );
    logic [23:0]     m2_rgb;
    logic [2:0]      m2_mode;
    logic [15:0]     m2_per;
    logic [23:0]     m2_total;
    logic [ModW-1:0] m2_seq;
    assign {m2_rgb, m2_mode, m2_per, m2_total, m2_seq} = m2_side;

    // Stage: breathe numerator phase*255 (or (P-phase)*255) over half period.
    logic        r3_v;
    logic [23:0] r3_rgb;
    logic [2:0]  r3_mode;
    logic [23:0] r3_num;
    logic [14:0] r3_half;
    logic        r3_blink_on;
    logic [15:0] n_ph;
    logic [15:0] n_d;
    logic [14:0] n_half;
    always_comb begin
        n_ph   = m2_seq[15:0];
        n_half = m2_per[15:1];
        n_d    = (n_ph < {1'b0, n_half}) ? n_ph : 16'(m2_per - n_ph);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= m2_v;
        end
        if (w_en) begin
            r3_rgb      <= m2_rgb;
            r3_mode     <= m2_mode;
            r3_num      <= 24'(n_d * 8'd255);
            r3_half     <= (n_half == '0) ? 15'd1 : n_half;
            r3_blink_on <= (r_cfg.cycle != '0) && (m2_seq < ModW'(m2_total))
                           && (m2_rem < ModW'(r_cfg.on_ms));
        end
    end
    logic r3_deg;
    assign r3_deg = (r_cfg.slow[15:1] == '0 && r3_mode == MODE_SLOW)
                    || (r_cfg.fast[15:1] == '0 && r3_mode == MODE_FAST);

    logic              d_v;
    logic [QW-1:0]     d_q;
    logic [DSideW-1:0] d_side;
    lpr_div_pipe u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r3_v),
        .i_num(r3_num), .i_den(r3_half),
        .i_side({r3_rgb, r3_mode, r3_blink_on, r3_deg}),
        .o_valid(d_v), .o_quo(d_q), .o_side(d_side)
    );
    logic [23:0] d_rgb;
    logic [2:0]  d_mode;
    logic        d_on;
    logic        d_deg;
    assign {d_rgb, d_mode, d_on, d_deg} = d_side;

    // Stage: choose level, multiply each channel.
    logic        r4_v;
    logic [7:0]  r4_lvl;
    logic [15:0] r4_p [3];
    logic [7:0]  n_lvl;
    always_comb begin
        case (d_mode)
            MODE_OFF:   n_lvl = 8'd0;
            MODE_SLOW,
            MODE_FAST:  n_lvl = (d_deg || d_q > 9'd255) ? 8'd255 : d_q[7:0];
            MODE_BLINK: n_lvl = d_on ? 8'd255 : 8'd0;
            default:    n_lvl = 8'd255;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= d_v;
        end
        if (w_en) begin
            r4_lvl  <= n_lvl;
            r4_p[0] <= d_rgb[23:16] * n_lvl;
            r4_p[1] <= d_rgb[15:8] * n_lvl;
            r4_p[2] <= d_rgb[7:0] * n_lvl;
        end
    end

    // Divide by 255: q = (x + (x>>8) + 1) >> 8 is exact for any 8-bit by 8-bit product.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r4_v;
        end
        if (w_en) begin
            r_od <= '{red_out: div255(r4_p[0]), green_out: div255(r4_p[1]),
                      blue_out: div255(r4_p[2]), level: r4_lvl};
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_out.ready |=> r_ov && $stable(r_od)) else $error("output lost");
    a_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r4_v && r4_lvl == 8'd0 |=> r_od.red_out == 8'd0) else $error("dim");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && d_v && d_mode == MODE_OFF |=> r4_lvl == 8'd0) else $error("off lvl");
endmodule
`default_nettype wire

>>> sim/led_pattern_renderer_test.sv
`timescale 1ns / 1ps
module led_pattern_renderer_test;
    import lpr_pkg::*;

    localparam int Latency = 2 * TimeW + QW + 4;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [IdxW-1:0] i_cfg_idx;
    logic [CfgW-1:0] i_cfg_data;

    lpr_if #(.W($bits(t_in)))  in_ch ();
    lpr_if #(.W($bits(t_out))) out_ch ();

    led_pattern_renderer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    // Shadow copy of the period/timing registers, kept in step with every write.
    t_cfg shadow_cfg;

    t_in  pending_items[$];
    t_out expected_pixels[$];

    int  mismatches;
    int  unexpected;
    int  accepted_items;
    int  checked_pixels;
    bit  stim_done;
    bit  in_taken;
    int  mode_hits[8];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Gap length: mostly none or short, now and then a long stretch.
    function automatic int pick_gap(input int idle_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll >= idle_pct) begin
            return 0;
        end
        if ($urandom_range(19) == 0) begin
            return $urandom_range(40, 10);
        end
        return $urandom_range(3, 1);
    endfunction

    // Triangle wave level over the given period, saturated at full scale.
    function automatic logic [7:0] breathe_level(input logic [TimeW-1:0] t,
                                                 input logic [CfgW-1:0] period);
        longint unsigned half;
        longint unsigned phase;
        longint unsigned lvl;
        half = period / 2;
        if (half == 0) begin
            return 8'd255;
        end
        phase = t % period;
        if (phase < half) begin
            lvl = (phase * 255) / half;
        end else begin
            lvl = ((period - phase) * 255) / half;
        end
        return (lvl > 255) ? 8'd255 : lvl[7:0];
    endfunction

    // Lit for the on-time of each cycle in the sequence, dark during the pause.
    function automatic logic [7:0] blink_level(input logic [TimeW-1:0] t,
                                               input logic [7:0] count);
        longint unsigned pulses;
        longint unsigned total;
        longint unsigned in_seq;
        longint unsigned cyc_pos;
        pulses = (count == 0) ? 1 : count;
        total = pulses * shadow_cfg.cycle;
        if (total == 0) begin
            return 8'd0;
        end
        in_seq = t % (total + shadow_cfg.pause);
        cyc_pos = in_seq % shadow_cfg.cycle;
        return (in_seq < total && cyc_pos < shadow_cfg.on_ms) ? 8'd255 : 8'd0;
    endfunction

    function automatic t_out render_pixel(input t_in item);
        t_out px;
        logic [7:0] lvl;
        case (item.pattern_mode)
            MODE_OFF:   lvl = 8'd0;
            MODE_SLOW:  lvl = breathe_level(item.time_ms, shadow_cfg.slow);
            MODE_FAST:  lvl = breathe_level(item.time_ms, shadow_cfg.fast);
            MODE_BLINK: lvl = blink_level(item.time_ms, item.pulse_count);
            default:    lvl = 8'd255;
        endcase
        px.red_out   = 8'((16'(item.red_in) * lvl) / 255);
        px.green_out = 8'((16'(item.green_in) * lvl) / 255);
        px.blue_out  = 8'((16'(item.blue_in) * lvl) / 255);
        px.level     = lvl;
        return px;
    endfunction

    // Driver: present queued items at the falling edge, with random gaps.
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else if (!in_ch.valid || in_taken) begin
            // Either nothing is on the bus or the last one was just taken.
            if (send_gap > 0) begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                in_ch.data  <= pending_items.pop_front();
                in_ch.valid <= 1'b1;
                send_gap = pick_gap(25);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Predict at the accepting edge, so the prediction uses the live settings.
    always @(posedge i_clk) begin
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken) begin
            expected_pixels.push_back(render_pixel(t_in'(in_ch.data)));
            mode_hits[in_ch.data[$bits(t_in)-25 -: 3]]++;
            accepted_items++;
        end
    end

    // Sink back-pressure: drop ready for random stretches.
    int stall_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_gap = 0;
        end else if (stall_gap > 0) begin
            stall_gap--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            stall_gap = pick_gap(20);
        end
    end

    // Monitor: compare each transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = t_out'(out_ch.data);
            if (expected_pixels.size() == 0) begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: output %h with no transaction outstanding", got);
                end
            end else begin
                want = expected_pixels.pop_front();
                checked_pixels++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: rgb/level expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.red_out, want.green_out, want.blue_out, want.level,
                                 got.red_out, got.green_out, got.blue_out, got.level);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SLOW:  shadow_cfg.slow  = val;
            REG_FAST:  shadow_cfg.fast  = val;
            REG_CYCLE: shadow_cfg.cycle = val;
            REG_ON:    shadow_cfg.on_ms = val;
            REG_PAUSE: shadow_cfg.pause = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [CfgW-1:0] slow, input logic [CfgW-1:0] fast,
                                 input logic [CfgW-1:0] cyc, input logic [CfgW-1:0] on_ms,
                                 input logic [CfgW-1:0] pause);
        write_reg(REG_SLOW, slow);
        write_reg(REG_FAST, fast);
        write_reg(REG_CYCLE, cyc);
        write_reg(REG_ON, on_ms);
        write_reg(REG_PAUSE, pause);
    endtask

    // Hold until every queued item is in and every prediction has been met.
    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_pixels.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    function automatic t_in make_item(input logic [2:0] mode, input logic [7:0] count,
                                      input logic [TimeW-1:0] t);
        t_in item;
        item.red_in       = 8'($urandom);
        item.green_in     = 8'($urandom);
        item.blue_in      = 8'($urandom);
        item.pattern_mode = mode;
        item.pulse_count  = count;
        item.time_ms      = t;
        return item;
    endfunction

    // Times mostly near the periods in play so wave edges get hit, some anywhere.
    function automatic logic [TimeW-1:0] pick_time();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(4 * (shadow_cfg.slow + 2));
            2: return $urandom_range(4 * (shadow_cfg.fast + 2));
            default: return $urandom_range(2 * (shadow_cfg.cycle * 8 + shadow_cfg.pause) + 4);
        endcase
    endfunction

    task automatic random_phase(input int count);
        t_in item;
        repeat (count) begin
            item = make_item(3'($urandom_range(7)),
                             ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8)),
                             pick_time());
            pending_items.push_back(item);
        end
        drain();
    endtask

    initial begin
        t_in item;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b0;
        stim_done = 1'b0;
        shadow_cfg = '{slow: 2000, fast: 600, cycle: 500, on_ms: 250, pause: 1000};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes of the colour and time, every mode at defaults.
        item = make_item(MODE_SOLID, 8'd0, 32'd0);
        item.red_in = 8'hFF; item.green_in = 8'h00; item.blue_in = 8'hFF;
        pending_items.push_back(item);
        item.red_in = 8'h00; item.green_in = 8'hFF; item.blue_in = 8'h00;
        item.time_ms = 32'hFFFF_FFFF;
        pending_items.push_back(item);
        pending_items.push_back(make_item(MODE_OFF, 8'hFF, 32'd123));
        pending_items.push_back(make_item(MODE_SLOW, 8'd0, 32'd0));
        pending_items.push_back(make_item(MODE_SLOW, 8'd0, 32'd1000));
        pending_items.push_back(make_item(MODE_SLOW, 8'd0, 32'd1999));
        pending_items.push_back(make_item(MODE_FAST, 8'd0, 32'd299));
        pending_items.push_back(make_item(MODE_FAST, 8'd0, 32'hFFFF_FFFF));
        // Blink count zero acts as one pulse; also the pause and a big count.
        pending_items.push_back(make_item(MODE_BLINK, 8'd0, 32'd100));
        pending_items.push_back(make_item(MODE_BLINK, 8'd0, 32'd600));
        pending_items.push_back(make_item(MODE_BLINK, 8'd3, 32'd1400));
        pending_items.push_back(make_item(MODE_BLINK, 8'hFF, 32'hFFFF_FFFF));
        // Undefined modes behave as solid.
        pending_items.push_back(make_item(3'd5, 8'd1, 32'd7));
        pending_items.push_back(make_item(3'd6, 8'd1, 32'd7));
        pending_items.push_back(make_item(3'd7, 8'd1, 32'd7));
        drain();

        // Odd and degenerate breathing periods, zero blink cycle, zero on-time.
        load_settings(16'd3, 16'd1, 16'd0, 16'd0, 16'd0);
        pending_items.push_back(make_item(MODE_SLOW, 8'd0, 32'd2));
        pending_items.push_back(make_item(MODE_SLOW, 8'd0, 32'd1));
        pending_items.push_back(make_item(MODE_FAST, 8'd0, 32'd5));
        pending_items.push_back(make_item(MODE_BLINK, 8'd4, 32'd9));
        drain();
        write_reg(REG_FAST, 16'd0);
        pending_items.push_back(make_item(MODE_FAST, 8'd0, 32'd17));
        random_phase(60);

        // Several random phases, minimum and maximum settings among them.
        load_settings(16'd2, 16'd2, 16'd1, 16'd1, 16'd0);
        random_phase(200);
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(200);
        load_settings(16'd2000, 16'd600, 16'd500, 16'd250, 16'd1000);
        random_phase(300);
        repeat (3) begin
            load_settings(16'($urandom_range(2, 4000)), 16'($urandom_range(2, 1000)),
                          16'($urandom_range(1, 300)), 16'($urandom_range(0, 350)),
                          16'($urandom_range(0, 800)));
            random_phase(200);
        end
        load_settings(16'd7, 16'd5, 16'd3, 16'd2, 16'd5);
        random_phase(250);

        $display("Ran %0d transactions (%0d checked) over ten register settings;",
                 accepted_items, checked_pixels);
        $display("modes off/solid/slow/fast/blink/undefined: %0d/%0d/%0d/%0d/%0d/%0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4],
                 mode_hits[5] + mode_hits[6] + mode_hits[7]);
        if (mismatches > 0 || expected_pixels.size() > 0) begin
            $display("%0d mismatches, %0d outstanding", mismatches, expected_pixels.size());
            $display("Some tests failed");
        end else begin
            $display("All tests passed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out");
        $display("Some tests failed");
        $finish;
    end
endmodule
